/* design/mcv_pkg.sv */
// Package for the multichannel valid convolution block.
// Holds sizes, item kinds, register indexes, payload and control structs.
`default_nettype none
package mcv_pkg;
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_KERNEL   = 5;
  localparam int MAX_DIM      = 32;
  localparam int WDEPTH = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int IDEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
  localparam int WAW = $clog2(WDEPTH);
  localparam int IAW = $clog2(IDEPTH);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int KW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int DW  = $clog2(MAX_DIM);

  localparam logic [1:0] KIND_WEIGHT  = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [2:0] REG_KSIZE  = 3'd0;
  localparam logic [2:0] REG_STRIDE = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_CHANS  = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         channel;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic signed [47:0] sum;
    logic               range_error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request and compute window origin
    logic clr;       // clear accumulator, reset counters
    logic issue;     // issue one read pair and advance counters
    logic emit;      // present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;       // request out of range
    logic last;      // final read pair issued
    logic drained;   // MAC pipe empty
  } dp_sts_t;
endpackage
`default_nettype wire

/* design/mcv_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module mcv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/mcv_ctrl.sv */
// Controller state machine for the convolution block.
// Depends on mcv_pkg.
`default_nettype none
module mcv_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [1:0]      kind,
  input  wire mcv_pkg::dp_sts_t sts,
  output logic                 busy,
  output mcv_pkg::dp_cmd_t     cmd
);
  import mcv_pkg::*;
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start && kind == KIND_COMPUTE) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.clr = 1'b1;
        state_nxt = sts.err ? S_EMIT : S_RUN;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (sts.last) state_nxt = S_DRAIN;
      end
      S_DRAIN: if (sts.drained) state_nxt = S_EMIT;
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

/* design/mcv_dp.sv */
// Datapath: config registers, weight/image stores, address counters, MAC.
// Depends on mcv_pkg and mcv_ram.
`default_nettype none
module mcv_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_accept,
  input  wire mcv_pkg::in_item_t in_item,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [5:0]        cfg_wdata,
  input  wire mcv_pkg::dp_cmd_t  cmd,
  output mcv_pkg::dp_sts_t       sts,
  output logic                   out_valid,
  output mcv_pkg::out_item_t     out_item
);
  import mcv_pkg::*;

  // configuration registers
  logic [2:0] ks_r, st_r;
  logic [5:0] h_r, w_r;
  logic [3:0] nc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r <= 3'd3; st_r <= 3'd1; h_r <= 6'd28; w_r <= 6'd28; nc_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KSIZE:  ks_r <= cfg_wdata[2:0];
        REG_STRIDE: st_r <= cfg_wdata[2:0];
        REG_HEIGHT: h_r  <= cfg_wdata;
        REG_WIDTH:  w_r  <= cfg_wdata;
        REG_CHANS:  nc_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // saturated register values
  logic [3:0] k;
  logic [2:0] s;
  logic [8:0] h, w;
  logic [6:0] nc;
  always_comb begin
    k  = (ks_r == 3'd0) ? 4'd1 : ((ks_r > 3'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : {1'b0, ks_r});
    s  = (st_r == 3'd0) ? 3'd1 : ((st_r > 3'd4) ? 3'd4 : st_r);
    h  = (h_r == 6'd0) ? 9'd1 : ((h_r > 6'(MAX_DIM)) ? 9'(MAX_DIM) : {3'b0, h_r});
    w  = (w_r == 6'd0) ? 9'd1 : ((w_r > 6'(MAX_DIM)) ? 9'(MAX_DIM) : {3'b0, w_r});
    nc = (nc_r == 4'd0) ? 7'd1 :
         ((nc_r > 4'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS) : {3'b0, nc_r});
  end

  // request registers
  logic [4:0] row_r, col_r;
  logic       err_r;
  logic [8:0] r0_r, c0_r;
  // range check: row*s + k <= h  <=>  row < out size
  logic [8:0] r0, c0;
  assign r0 = 9'(in_item.row) * 9'(s);
  assign c0 = 9'(in_item.col) * 9'(s);
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= in_item.row;
      col_r <= in_item.col;
      r0_r  <= r0;
      c0_r  <= c0;
    end
    if (cmd.clr) err_r <= (10'(r0_r) + 10'(k) > 10'(h)) || (10'(c0_r) + 10'(k) > 10'(w));
  end
  assign sts.err = (10'(r0_r) + 10'(k) > 10'(h)) || (10'(c0_r) + 10'(k) > 10'(w));

  // store writes
  logic          wwe, iwe;
  logic [WAW-1:0] wwa;
  logic [IAW-1:0] iwa;
  assign wwe = in_accept && in_item.kind == KIND_WEIGHT &&
               32'(in_item.channel) < MAX_CHANNELS &&
               32'(in_item.row) < MAX_KERNEL && 32'(in_item.col) < MAX_KERNEL;
  assign iwe = in_accept && in_item.kind == KIND_PIXEL &&
               32'(in_item.channel) < MAX_CHANNELS &&
               32'(in_item.row) < MAX_DIM && 32'(in_item.col) < MAX_DIM;
  assign wwa = WAW'((32'(in_item.channel) * MAX_KERNEL + 32'(in_item.row)) * MAX_KERNEL
                    + 32'(in_item.col));
  assign iwa = IAW'((32'(in_item.channel) * MAX_DIM + 32'(in_item.row)) * MAX_DIM
                    + 32'(in_item.col));

  // window counters
  logic [CHW-1:0] c_r;
  logic [KW-1:0]  ki_r, kj_r;
  logic [WAW-1:0] wra;
  logic [IAW-1:0] ira;
  logic           lastk, lastj, lastc;
  assign lastj = (4'(kj_r) == k - 4'd1);
  assign lastk = (4'(ki_r) == k - 4'd1);
  assign lastc = (7'(c_r) == nc - 7'd1);
  assign sts.last = lastj && lastk && lastc;
  assign wra = WAW'((32'(c_r) * MAX_KERNEL + 32'(ki_r)) * MAX_KERNEL + 32'(kj_r));
  assign ira = IAW'((32'(c_r) * MAX_DIM + 32'(r0_r) + 32'(ki_r)) * MAX_DIM
                    + 32'(c0_r) + 32'(kj_r));
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      c_r <= '0; ki_r <= '0; kj_r <= '0;
    end else if (cmd.issue) begin
      if (!lastj) kj_r <= kj_r + 1'b1;
      else begin
        kj_r <= '0;
        if (!lastk) ki_r <= ki_r + 1'b1;
        else begin
          ki_r <= '0;
          c_r  <= c_r + 1'b1;
        end
      end
    end
  end

  logic signed [15:0] wrd, ird;
  mcv_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wram (
    .clk(clk), .we(wwe), .waddr(wwa), .wdata(in_item.value), .raddr(wra), .rdata(wrd));
  mcv_ram #(.WIDTH(16), .DEPTH(IDEPTH)) u_iram (
    .clk(clk), .we(iwe), .waddr(iwa), .wdata(in_item.value), .raddr(ira), .rdata(ird));

  // MAC pipe: read -> multiply -> accumulate
  logic               v1_r, v2_r;
  logic signed [31:0] prod_r;
  logic signed [47:0] acc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
    prod_r <= ird * wrd;
    if (cmd.clr) acc_r <= '0;
    else if (v2_r) acc_r <= acc_r + 48'(prod_r);
  end
  assign sts.drained = !v1_r && !v2_r && !cmd.issue;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.emit;
    if (cmd.emit) begin
      out_item.out_row     <= row_r;
      out_item.out_col     <= col_r;
      out_item.sum         <= err_r ? 48'sd0 : acc_r;
      out_item.range_error <= err_r;
    end
  end
endmodule
`default_nettype wire

/* design/multichannel_conv2d_valid.sv */
// Top level of the multichannel valid strided 2D convolution block.
// Depends on mcv_pkg, mcv_ctrl, mcv_dp, mcv_ram.
//
// Usage:
//  Input: a transfer happens when start is high and busy is low. Load items
//  (weight, pixel) leave busy low. A compute item raises
//  busy until its result has been presented.
//  Output: out_valid is high for one cycle with out_data; it cannot be held.
//  A compute item is worked by the single MAC walking every channel and
//  kernel tap in turn (one store read pair per cycle). An out-of-range
//  request skips that walk and goes straight to its result.
//  busy is already low while out_valid is high, so the next item can be
//  taken in that same cycle.
//  Config: cfg_we writes cfg_wdata to register cfg_index in that cycle;
//  write only while idle. Indexes above 4 are ignored.
//  Reset: registers return to 3,1,28,28,1; the stores are not cleared and
//  must be written before they are read.
`default_nettype none
module multichannel_conv2d_valid (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mcv_pkg::in_item_t  in_data,
  output logic                    out_valid,
  output mcv_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [5:0]         cfg_wdata
);
  import mcv_pkg::*;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    acc;
  assign acc = start && !busy;

  mcv_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(acc), .kind(in_data.kind),
    .sts(sts), .busy(busy), .cmd(cmd));

  mcv_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_accept(acc), .in_item(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .sts(sts), .out_valid(out_valid), .out_item(out_data));
endmodule
`default_nettype wire

/* design/mcv_checker.sv */
// Port-level checker for the convolution block, bound to the top level.
// Depends on mcv_pkg.
`default_nettype none
module mcv_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire mcv_pkg::in_item_t in_data,
  input wire logic              out_valid,
  input wire mcv_pkg::out_item_t out_data
);
  import mcv_pkg::*;
  // a compute transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.kind == KIND_COMPUTE |=> busy) else $error("no busy");
  // loads never raise busy
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !(start && in_data.kind == KIND_COMPUTE) |=> !busy) else $error("busy on load");
  // a result ends the busy period
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy with result");
  // error results carry zero sum
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |-> out_data.sum == 48'sd0) else $error("err sum");
  // results are single-cycle strobes
  a_strb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
endmodule

bind multichannel_conv2d_valid mcv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
  .out_valid(out_valid), .out_data(out_data));
`default_nettype wire
